>>> hdl/ppdb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppdb_pkg
// Shared types and constants of the point projection depth buffer.
// ----------------------------------------------------------------------------
package ppdb_pkg;

  // input item action codes
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_SPLAT = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_ZERO_Z  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_K00    = 3'd0;
  localparam logic [2:0] REG_K01    = 3'd1;
  localparam logic [2:0] REG_K02    = 3'd2;
  localparam logic [2:0] REG_K10    = 3'd3;
  localparam logic [2:0] REG_K11    = 3'd4;
  localparam logic [2:0] REG_K12    = 3'd5;
  localparam logic [2:0] REG_WIDTH  = 3'd6;
  localparam logic [2:0] REG_HEIGHT = 3'd7;

  // configuration reset values
  localparam logic [31:0] K00_RESET    = 32'd38226033;
  localparam logic [31:0] K01_RESET    = 32'd0;
  localparam logic [31:0] K02_RESET    = 32'd20971520;
  localparam logic [31:0] K10_RESET    = 32'd0;
  localparam logic [31:0] K11_RESET    = 32'd37972296;
  localparam logic [31:0] K12_RESET    = 32'd15728640;
  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [9:0]  HEIGHT_RESET = 10'd480;

  // command fields sized for the largest supported image and index
  localparam int CMD_COORD_W = 12;
  localparam int CMD_INDEX_W = 32;

  // top two rows of the intrinsic matrix, entry 3*row+col
  typedef logic [5:0][31:0] kmat_t;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_SPLAT,
    CMD_READ,
    CMD_DROP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [1:0]             status;
    logic [CMD_COORD_W-1:0] col;
    logic [CMD_COORD_W-1:0] row;
    logic [31:0]            z;
    logic [CMD_INDEX_W-1:0] number;
  } cmd_t;

endpackage

>>> hdl/ppdb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppdb_queue
// Small FIFO between the projection front end and the depth store.
// ----------------------------------------------------------------------------
module ppdb_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  logic [DW-1:0] push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output logic [DW-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [DW-1:0]   slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CNTW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers wrap at DEPTH
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(DEPTH))
    else $error("queue count above depth");

endmodule

>>> hdl/ppdb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppdb_front
// Accepts items, classifies them and projects splat points to a pixel.
// ----------------------------------------------------------------------------
module ppdb_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                hold,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          action,
  input  logic signed [31:0]  point_x,
  input  logic signed [31:0]  point_y,
  input  logic signed [31:0]  point_z,
  input  logic [23:0]         point_number,
  input  logic [9:0]          read_col,
  input  logic [8:0]          read_row,
  input  ppdb_pkg::kmat_t     kmat,
  input  logic [10:0]         image_width,
  input  logic [9:0]          image_height,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output ppdb_pkg::cmd_t      cmd
);

  localparam int WB = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
  localparam int HB = ($clog2(MAX_HEIGHT + 1) > 10) ? $clog2(MAX_HEIGHT + 1) : 10;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int DIV_STEPS = 64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ABS,
    S_DIV,
    S_ROUND,
    S_CHECK,
    S_PUSH
  } state_t;

  state_t               state;
  logic                 pass;       // 0: column, 1: row
  logic [1:0]           step;
  logic signed [31:0]   px;
  logic signed [31:0]   py;
  logic signed [31:0]   pz;
  logic [31:0]          pnum;
  logic                 z_neg;
  logic [47:0]          divisor;
  logic signed [63:0]   prod;
  logic signed [65:0]   acc;
  logic [63:0]          dividend;
  logic [47:0]          rem;
  logic [63:0]          quo;
  logic [5:0]           bit_cnt;
  logic                 mag_neg;
  logic [63:0]          q_round;
  logic                 r_neg;
  logic                 col_out;
  logic [CW-1:0]        col_val;
  ppdb_pkg::cmd_t       cmd_q;

  logic [WB-1:0]        iw_ext;
  logic [WB-1:0]        ew;
  logic [HB-1:0]        ih_ext;
  logic [HB-1:0]        eh;
  logic [2:0]           kidx;
  logic signed [31:0]   mul_a;
  logic signed [31:0]   mul_b;
  logic [48:0]          trial;
  logic                 fits;
  logic                 round_up;
  logic [63:0]          lim;
  logic                 chk_out;
  logic [31:0]          zmag;
  logic                 rd_out;
  logic                 accept;
  ppdb_pkg::cmd_t       idle_cmd;
  ppdb_pkg::cmd_t       final_cmd;

  // effective image size
  assign iw_ext = WB'(image_width);
  assign ew     = (iw_ext > WB'(MAX_WIDTH)) ? WB'(MAX_WIDTH) : iw_ext;
  assign ih_ext = HB'(image_height);
  assign eh     = (ih_ext > HB'(MAX_HEIGHT)) ? HB'(MAX_HEIGHT) : ih_ext;

  assign in_ready  = (state == S_IDLE) && !hold;
  assign accept    = in_valid && in_ready;
  assign cmd_valid = (state == S_PUSH);
  assign cmd       = cmd_q;

  // one shared multiplier walks k*x, k*y, k*z of the current row
  assign kidx  = (step == 2'd3) ? 3'd0 : (pass ? 3'd3 + {1'b0, step} : {1'b0, step});
  assign mul_a = $signed(kmat[kidx]);
  assign mul_b = (step == 2'd0) ? px : ((step == 2'd1) ? py : pz);

  // restoring divide, one quotient bit a cycle
  assign trial    = {rem, dividend[63]};
  assign fits     = (trial >= {1'b0, divisor});
  assign round_up = ({rem, 1'b0} >= {1'b0, divisor});

  // a negative result that rounds to zero still lands on pixel zero
  assign lim     = pass ? 64'(eh) : 64'(ew);
  assign chk_out = (r_neg && (q_round != '0)) || (q_round >= lim);

  assign zmag   = point_z[31] ? 32'(-point_z) : 32'(point_z);
  assign rd_out = (WB'(read_col) >= ew) || (HB'(read_row) >= eh);

  always_comb begin
    idle_cmd        = '0;
    idle_cmd.z      = 32'(point_z);
    idle_cmd.number = 32'(point_number);
    case (action)
      ppdb_pkg::ACT_CLEAR: begin
        idle_cmd.kind   = ppdb_pkg::CMD_CLEAR;
        idle_cmd.status = ppdb_pkg::ST_OK;
      end
      ppdb_pkg::ACT_SPLAT: begin
        // only pushed as is when z is zero
        idle_cmd.kind   = ppdb_pkg::CMD_DROP;
        idle_cmd.status = ppdb_pkg::ST_ZERO_Z;
      end
      ppdb_pkg::ACT_READ: begin
        if (rd_out) begin
          idle_cmd.kind   = ppdb_pkg::CMD_DROP;
          idle_cmd.status = ppdb_pkg::ST_OUTSIDE;
        end else begin
          idle_cmd.kind   = ppdb_pkg::CMD_READ;
          idle_cmd.status = ppdb_pkg::ST_OK;
          idle_cmd.col    = ppdb_pkg::CMD_COORD_W'(read_col);
          idle_cmd.row    = ppdb_pkg::CMD_COORD_W'(read_row);
        end
      end
      default: begin
        idle_cmd.kind   = ppdb_pkg::CMD_DROP;
        idle_cmd.status = ppdb_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    final_cmd        = '0;
    final_cmd.z      = 32'(pz);
    final_cmd.number = pnum;
    if (col_out || chk_out) begin
      final_cmd.kind   = ppdb_pkg::CMD_DROP;
      final_cmd.status = ppdb_pkg::ST_OUTSIDE;
    end else begin
      final_cmd.kind   = ppdb_pkg::CMD_SPLAT;
      final_cmd.status = ppdb_pkg::ST_OK;
      final_cmd.col    = ppdb_pkg::CMD_COORD_W'(col_val);
      final_cmd.row    = ppdb_pkg::CMD_COORD_W'(RW'(q_round));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            px      <= point_x;
            py      <= point_y;
            pz      <= point_z;
            pnum    <= 32'(point_number);
            z_neg   <= point_z[31];
            divisor <= {zmag, 16'h0000};
            pass    <= 1'b0;
            step    <= 2'd0;
            acc     <= '0;
            cmd_q   <= idle_cmd;
            if (action == ppdb_pkg::ACT_SPLAT && point_z != '0) begin
              state <= S_MUL;
            end else begin
              state <= S_PUSH;
            end
          end
        end
        S_MUL: begin
          if (step != 2'd3) begin
            prod <= mul_a * mul_b;
          end
          if (step != 2'd0) begin
            acc <= acc + 66'(prod);
          end
          step <= step + 2'd1;
          if (step == 2'd3) begin
            state <= S_ABS;
          end
        end
        S_ABS: begin
          mag_neg  <= acc[65];
          dividend <= acc[65] ? 64'(-acc) : 64'(acc);
          rem      <= '0;
          quo      <= '0;
          bit_cnt  <= '0;
          state    <= S_DIV;
        end
        S_DIV: begin
          dividend <= {dividend[62:0], 1'b0};
          if (fits) begin
            rem <= 48'(trial - {1'b0, divisor});
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= trial[47:0];
            quo <= {quo[62:0], 1'b0};
          end
          bit_cnt <= bit_cnt + 6'd1;
          if (bit_cnt == 6'(DIV_STEPS - 1)) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          // half away from zero on the magnitude
          q_round <= quo + 64'(round_up);
          r_neg   <= mag_neg ^ z_neg;
          state   <= S_CHECK;
        end
        S_CHECK: begin
          if (!pass) begin
            col_out <= chk_out;
            col_val <= CW'(q_round);
            pass    <= 1'b1;
            step    <= 2'd0;
            acc     <= '0;
            state   <= S_MUL;
          end else begin
            cmd_q <= final_cmd;
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (cmd_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (divisor != '0))
    else $error("divide started with zero divisor");

  a_splat_ok: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd.kind == ppdb_pkg::CMD_SPLAT) |-> (cmd.status == ppdb_pkg::ST_OK))
    else $error("splat command carries a drop status");

endmodule

>>> hdl/ppdb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppdb_back
// Depth store: clear sweeps, nearest-wins update, pixel reads, result register.
// ----------------------------------------------------------------------------
module ppdb_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 512,
  parameter int INDEX_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  output logic               init_busy,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  ppdb_pkg::cmd_t     cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [9:0]         pixel_col,
  output logic [8:0]         pixel_row,
  output logic               replaced,
  output logic signed [31:0] depth_out,
  output logic [23:0]        index_out,
  output logic               index_valid
);

  localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW   = $clog2(NPIX);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int EW   = 33 + INDEX_BITS;   // {written, index, depth}

  typedef enum logic [2:0] {
    B_SWEEP,
    B_IDLE,
    B_FETCH,
    B_UPDATE,
    B_FINISH
  } state_t;

  logic [EW-1:0]       store [NPIX];
  state_t              state;
  logic [AW-1:0]       sweep_cnt;
  ppdb_pkg::cmd_t      cur;
  logic [AW-1:0]       addr;
  logic [EW-1:0]       rd_data;

  logic [AW-1:0]         cmd_addr;
  logic signed [31:0]    stored;
  logic [INDEX_BITS-1:0] sidx;
  logic                  sflag;
  logic                  replace;
  logic                  slot_free;
  logic                  out_load;
  logic                  sweep_last;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [EW-1:0]         mem_wdata;

  assign cmd_addr = AW'(RW'(cmd.row)) * AW'(MAX_WIDTH) + AW'(CW'(cmd.col));
  assign stored   = $signed(rd_data[31:0]);
  assign sidx     = rd_data[32 +: INDEX_BITS];
  assign sflag    = rd_data[EW-1];
  assign replace  = (cur.kind == ppdb_pkg::CMD_SPLAT) &&
                    ((stored <= 0) || ($signed(cur.z) < stored));
  assign slot_free  = !out_valid || out_ready;
  // result register loads a new item this cycle
  assign out_load   = slot_free && ((state == B_UPDATE) || (state == B_FINISH));
  assign sweep_last = (sweep_cnt == AW'(NPIX - 1));
  assign cmd_ready  = (state == B_IDLE);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = {1'b1, INDEX_BITS'(cur.number), cur.z};
    case (state)
      B_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_cnt;
        mem_wdata = '0;
      end
      B_UPDATE: begin
        mem_we = slot_free && replace;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    rd_data <= store[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_SWEEP;
      init_busy <= 1'b1;
      sweep_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_SWEEP: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_last) begin
            sweep_cnt <= '0;
            init_busy <= 1'b0;
            state     <= init_busy ? B_IDLE : B_FINISH;
          end
        end
        B_IDLE: begin
          if (cmd_valid) begin
            cur  <= cmd;
            addr <= cmd_addr;
            case (cmd.kind)
              ppdb_pkg::CMD_CLEAR: state <= B_SWEEP;
              ppdb_pkg::CMD_READ:  state <= B_FETCH;
              ppdb_pkg::CMD_SPLAT: state <= B_FETCH;
              default:             state <= B_FINISH;
            endcase
          end
        end
        B_FETCH: begin
          state <= B_UPDATE;
        end
        B_UPDATE: begin
          if (slot_free) begin
            out_valid   <= 1'b1;
            status      <= ppdb_pkg::ST_OK;
            pixel_col   <= 10'(cur.col);
            pixel_row   <= 9'(cur.row);
            replaced    <= replace;
            depth_out   <= replace ? $signed(cur.z) : stored;
            index_out   <= 24'(replace ? INDEX_BITS'(cur.number) : sidx);
            index_valid <= replace | sflag;
            state       <= B_IDLE;
          end
        end
        B_FINISH: begin
          if (slot_free) begin
            out_valid   <= 1'b1;
            status      <= cur.status;
            pixel_col   <= '0;
            pixel_row   <= '0;
            replaced    <= 1'b0;
            depth_out   <= '0;
            index_out   <= '0;
            index_valid <= 1'b0;
            state       <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  a_no_result_in_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !out_valid)
    else $error("result during power-up clear");

  a_drop_is_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ppdb_pkg::ST_OK) |->
      (depth_out == '0 && !index_valid && !replaced))
    else $error("dropped item carries pixel data");

endmodule

>>> hdl/point_projection_depth_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_projection_depth_buffer
// Projects Q16.16 points through a pinhole intrinsic matrix and keeps the
// nearest point per pixel in a depth/index store.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  in       | in_valid / in_ready  | action, point_x/y/z, point_number,
//           |                      | read_col, read_row
//  out      | out_valid / out_ready| status, pixel_col, pixel_row, replaced,
//           |                      | depth_out, index_out, index_valid
//  cfg      | cfg_write            | cfg_index, cfg_data (write only)
//
// Splat: one shared 32x32 multiplier and a 64-step restoring divider,
//   run once for the column and once for the row; the front end takes no
//   new item until the splat's command has gone into the queue.
// Read, drop and unused actions skip the projection and go straight to
//   the queue; the front end takes the next item once one of these is
//   pushed.
// Clear: sweeps every MAX_WIDTH*MAX_HEIGHT store entry, one per cycle.
// Reset: all MAX_WIDTH*MAX_HEIGHT store entries (524288 at defaults) are
//   swept to zero; in_ready stays low until it is done. Config writes are taken.
// A held result does not stop the front end: it keeps projecting the next
//   item into the two-entry command queue until that queue is full.
// ----------------------------------------------------------------------------
module point_projection_depth_buffer #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 512,
  parameter int INDEX_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic [23:0]        point_number,
  input  logic [9:0]         read_col,
  input  logic [8:0]         read_row,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [9:0]         pixel_col,
  output logic [8:0]         pixel_row,
  output logic               replaced,
  output logic signed [31:0] depth_out,
  output logic [23:0]        index_out,
  output logic               index_valid
);

  ppdb_pkg::kmat_t  kmat;
  logic [10:0]      image_width;
  logic [9:0]       image_height;

  logic             init_busy;
  logic             f_cmd_valid;
  logic             f_cmd_ready;
  ppdb_pkg::cmd_t   f_cmd;
  logic             b_cmd_valid;
  logic             b_cmd_ready;
  ppdb_pkg::cmd_t   b_cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kmat[0]      <= ppdb_pkg::K00_RESET;
      kmat[1]      <= ppdb_pkg::K01_RESET;
      kmat[2]      <= ppdb_pkg::K02_RESET;
      kmat[3]      <= ppdb_pkg::K10_RESET;
      kmat[4]      <= ppdb_pkg::K11_RESET;
      kmat[5]      <= ppdb_pkg::K12_RESET;
      image_width  <= ppdb_pkg::WIDTH_RESET;
      image_height <= ppdb_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ppdb_pkg::REG_K00:    kmat[0]      <= cfg_data;
        ppdb_pkg::REG_K01:    kmat[1]      <= cfg_data;
        ppdb_pkg::REG_K02:    kmat[2]      <= cfg_data;
        ppdb_pkg::REG_K10:    kmat[3]      <= cfg_data;
        ppdb_pkg::REG_K11:    kmat[4]      <= cfg_data;
        ppdb_pkg::REG_K12:    kmat[5]      <= cfg_data;
        ppdb_pkg::REG_WIDTH:  image_width  <= cfg_data[10:0];
        ppdb_pkg::REG_HEIGHT: image_height <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  // front end: classify, range check reads, project splats
  ppdb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .hold         (init_busy),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .point_number (point_number),
    .read_col     (read_col),
    .read_row     (read_row),
    .kmat         (kmat),
    .image_width  (image_width),
    .image_height (image_height),
    .cmd_valid    (f_cmd_valid),
    .cmd_ready    (f_cmd_ready),
    .cmd          (f_cmd)
  );

  // decouples projection from the store
  ppdb_queue #(
    .DW    ($bits(ppdb_pkg::cmd_t)),
    .DEPTH (2)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_cmd_valid),
    .push_ready (f_cmd_ready),
    .push_data  (f_cmd),
    .pop_valid  (b_cmd_valid),
    .pop_ready  (b_cmd_ready),
    .pop_data   (b_cmd)
  );

  // back end: depth store and result register
  ppdb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .init_busy   (init_busy),
    .cmd_valid   (b_cmd_valid),
    .cmd_ready   (b_cmd_ready),
    .cmd         (b_cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .pixel_col   (pixel_col),
    .pixel_row   (pixel_row),
    .replaced    (replaced),
    .depth_out   (depth_out),
    .index_out   (index_out),
    .index_valid (index_valid)
  );

endmodule

>>> tb/tb_point_projection_depth_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_projection_depth_buffer
// Self-checking bench for the point projection depth buffer. Items go in
// through a valid/ready sender task. A behavioral projector, rounding half
// away from zero, and a sparse shadow of the depth/index store predict each
// result. A monitor checks the results in order, field by field.
// ----------------------------------------------------------------------------
module tb_point_projection_depth_buffer;

  localparam logic [1:0] ACT_UNUSED = 2'd3;  // no package name for action 3
  localparam int         MAXW       = 1024;
  localparam int         MAXH       = 512;
  localparam int         DRAIN_WAIT = 400;     // > read/splat latency
  localparam longint     CYCLE_CAP  = 9000000; // reset + clear sweeps + splats

  typedef struct {
    logic [1:0]  status;
    logic [9:0]  col;
    logic [8:0]  row;
    logic        replaced;
    logic [31:0] depth;
    logic [23:0] index;
    logic        ivalid;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = '0;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
  logic [23:0] point_number = '0;
  logic [9:0] read_col = '0;
  logic [8:0] read_row = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [9:0] pixel_col;
  logic [8:0] pixel_row;
  logic replaced;
  logic signed [31:0] depth_out;
  logic [23:0] index_out;
  logic index_valid;

  always #6 clk = ~clk;

  point_projection_depth_buffer u_top (.*);

  // shadow configuration and sparse shadow store (absent key = zero entry)
  logic signed [31:0] kshadow [6];
  logic [10:0] width_shadow;
  logic [9:0]  height_shadow;
  logic [31:0] depth_shadow [int];
  logic [23:0] index_shadow [int];

  pixel_result_t pending_results[$];
  int landed_pixels[$];     // recent hit addresses, used to aim reads
  int err_count = 0;

  // idle controls, shared by the sender task and the receiver process
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit recv_hold = 1'b0;

  // ray pool: scaling a ray keeps its pixel, so depth fights happen often
  logic signed [31:0] ray_x [24], ray_y [24], ray_z [24];

  // --------------------------------------------------------------------------
  // projection: round((a*x + b*y + c*z) / (z*2^16)), half away from zero
  // --------------------------------------------------------------------------
  function automatic logic signed [127:0] project_coord(
      logic signed [31:0] a, logic signed [31:0] b, logic signed [31:0] c,
      logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
    logic signed [127:0] num, mag, dmag, q, r;
    logic signed [127:0] wa, wb, wc, wx, wy, wz;
    wa = a; wb = b; wc = c; wx = x; wy = y; wz = z;
    num  = wa * wx + wb * wy + wc * wz;
    mag  = (num < 0) ? -num : num;
    dmag = ((wz < 0) ? -wz : wz) <<< 16;
    q = mag / dmag;
    r = mag % dmag;
    if (r >= dmag - r) q = q + 1;
    if ((num < 0) != (wz < 0)) q = -q;
    return q;
  endfunction

  // work out the result of one accepted item and update the shadow store
  function automatic pixel_result_t predict_pixel(
      logic [1:0] act, logic signed [31:0] x, logic signed [31:0] y,
      logic signed [31:0] z, logic [23:0] num, logic [9:0] rc, logic [8:0] rr);
    pixel_result_t res;
    logic signed [127:0] c128, r128, w, h;
    logic signed [31:0] stored;
    int addr;
    res = '{default: '0};
    w = (width_shadow > MAXW) ? 128'(MAXW) : 128'(width_shadow);
    h = (height_shadow > MAXH) ? 128'(MAXH) : 128'(height_shadow);
    case (act)
      ppdb_pkg::ACT_CLEAR: begin
        depth_shadow.delete();
        index_shadow.delete();
        landed_pixels.delete();
        return res;
      end
      ACT_UNUSED: return res;
      ppdb_pkg::ACT_SPLAT: begin
        if (z == 0) begin
          res.status = ppdb_pkg::ST_ZERO_Z;
          return res;
        end
        c128 = project_coord(kshadow[0], kshadow[1], kshadow[2], x, y, z);
        r128 = project_coord(kshadow[3], kshadow[4], kshadow[5], x, y, z);
        if (c128 < 0 || r128 < 0 || c128 >= w || r128 >= h) begin
          res.status = ppdb_pkg::ST_OUTSIDE;
          return res;
        end
        addr = int'(r128) * MAXW + int'(c128);
        stored = depth_shadow.exists(addr) ? depth_shadow[addr] : '0;
        if (stored <= 0 || z < stored) begin
          depth_shadow[addr] = z;
          index_shadow[addr] = num;
          res.replaced = 1'b1;
        end
        landed_pixels.push_back(addr);
        if (landed_pixels.size() > 32) void'(landed_pixels.pop_front());
      end
      default: begin  // read
        if (rc >= w || rr >= h) begin
          res.status = ppdb_pkg::ST_OUTSIDE;
          return res;
        end
        addr = int'(rr) * MAXW + int'(rc);
      end
    endcase
    res.status = ppdb_pkg::ST_OK;
    res.col    = 10'(addr % MAXW);
    res.row    = 9'(addr / MAXW);
    res.ivalid = index_shadow.exists(addr);
    res.depth  = res.ivalid ? depth_shadow[addr] : '0;
    res.index  = res.ivalid ? index_shadow[addr] : '0;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // sender: valid stays up across back-to-back items, payload held until taken
  // --------------------------------------------------------------------------
  task automatic send_item(logic [1:0] act, logic signed [31:0] x,
      logic signed [31:0] y, logic signed [31:0] z, logic [23:0] num,
      logic [9:0] rc, logic [8:0] rr);
    action <= act; point_x <= x; point_y <= y; point_z <= z;
    point_number <= num; read_col <= rc; read_row <= rr;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_pixel(act, x, y, z, num, rc, rr));
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic splat(logic signed [31:0] x, logic signed [31:0] y,
      logic signed [31:0] z, logic [23:0] num);
    send_item(ppdb_pkg::ACT_SPLAT, x, y, z, num, '0, '0);
  endtask

  task automatic read_pixel(logic [9:0] rc, logic [8:0] rr);
    send_item(ppdb_pkg::ACT_READ, $urandom, $urandom, $urandom, 24'($urandom), rc, rr);
  endtask

  // drop valid right at the accepting edge, then let the block run dry
  task automatic wait_idle();
    if (in_valid) begin
      in_valid <= 1'b0;
    end
    wait (pending_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx < 6) kshadow[idx] = val;
    else if (idx == ppdb_pkg::REG_WIDTH) width_shadow = val[10:0];
    else height_shadow = val[9:0];
  endtask

  task automatic load_camera(logic [31:0] k00, logic [31:0] k01, logic [31:0] k02,
      logic [31:0] k10, logic [31:0] k11, logic [31:0] k12,
      logic [10:0] w, logic [9:0] h);
    wait_idle();
    write_reg(ppdb_pkg::REG_K00, k00);
    write_reg(ppdb_pkg::REG_K01, k01);
    write_reg(ppdb_pkg::REG_K02, k02);
    write_reg(ppdb_pkg::REG_K10, k10);
    write_reg(ppdb_pkg::REG_K11, k11);
    write_reg(ppdb_pkg::REG_K12, k12);
    write_reg(ppdb_pkg::REG_WIDTH, 32'(w));
    write_reg(ppdb_pkg::REG_HEIGHT, 32'(h));
  endtask

  // clear, then a read that cannot pass before the sweep is done
  task automatic clear_image();
    send_item(ppdb_pkg::ACT_CLEAR, $urandom, $urandom, $urandom, 24'($urandom),
              10'($urandom), 9'($urandom));
    read_pixel('0, '0);
  endtask

  function automatic void new_ray_pool();
    for (int i = 0; i < 24; i++) begin
      ray_z[i] = $urandom_range(32'h0000_1000, 32'h0001_0000);
      ray_x[i] = $signed($urandom_range(0, 2 * ray_z[i])) - ray_z[i];
      ray_y[i] = $signed($urandom_range(0, 2 * ray_z[i])) - ray_z[i];
    end
  endfunction

  // mostly pooled rays at random depth, with reads, noise and odd actions
  task automatic random_items(int count);
    int pick, ri, scale;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 66) begin
        ri = $urandom_range(23);
        scale = $urandom_range(1, 90);
        if ($urandom_range(19) == 0) scale = -scale;  // behind camera, same pixel
        splat(ray_x[ri] * scale, ray_y[ri] * scale, ray_z[ri] * scale, 24'($urandom));
      end else if (pick < 74 && landed_pixels.size() > 0) begin
        ri = landed_pixels[$urandom_range(landed_pixels.size() - 1)];
        read_pixel(10'(ri % MAXW), 9'(ri / MAXW));
      end else if (pick < 84) begin
        read_pixel(10'($urandom), 9'($urandom));
      end else if (pick < 95) begin
        splat($urandom, $urandom, $urandom, 24'($urandom));
      end else if (pick < 98) begin
        splat($urandom, $urandom, '0, 24'($urandom));
      end else begin
        send_item(ACT_UNUSED, $urandom, $urandom, $urandom, 24'($urandom),
                  10'($urandom), 9'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // test tasks
  // --------------------------------------------------------------------------
  task automatic test_directed_defaults();
    read_pixel(10'd639, 9'd479);                      // last pixel, empty
    read_pixel(10'd640, 9'd0);                        // just past width
    read_pixel(10'd1023, 9'd511);                     // all ones, outside
    splat('0, '0, 32'sh0001_0000, 24'hFFFFFF);        // principal point
    splat('0, '0, 32'sh0000_8000, 24'h000000);        // nearer, replaces
    splat('0, '0, 32'sh0002_0000, 24'h123456);        // farther, kept
    splat('0, '0, 32'sh0000_8000, 24'h654321);        // equal depth, kept
    splat('0, '0, 32'sh8000_0000, 24'h000001);        // most negative z
    splat('0, '0, 32'sh7FFF_FFFF, 24'h000002);        // stored <= 0, replaces
    splat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0000_0001, 24'h0);
    splat(32'sh8000_0000, 32'sh8000_0000, 32'sh0000_0001, 24'h0);
    splat(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 24'hABCDEF);
    splat(32'sh0001_0000, 32'sh0001_0000, '0, 24'hFFFFFF);  // zero depth
    splat('0, '0, 32'shFFFF_FFFF, 24'h0);              // z = -1
    send_item(ACT_UNUSED, '1, '1, '1, '1, '1, '1);
    read_pixel(10'd320, 9'd240);
    clear_image();
    read_pixel(10'd320, 9'd240);                       // empty after clear
  endtask

  // unit focal length, principal point 10: u = x/z + 10, halves round out
  task automatic test_rounding();
    load_camera(32'h0001_0000, 0, 32'h000A_0000, 0, 32'h0001_0000, 32'h000A_0000,
                11'd64, 10'd64);
    splat(32'sh0000_8000, 32'sh0000_8000, 32'sh0001_0000, 24'd1);   // 10.5
    splat(-32'sh0000_8000, -32'sh0000_8000, 32'sh0001_0000, 24'd2); // 9.5
    splat(32'sh0000_7FFF, -32'sh0000_8001, 32'sh0001_0000, 24'd3);
    splat(-32'sh0000_8000, 32'sh0000_8000, -32'sh0001_0000, 24'd4); // neg z
    splat(-32'sh000A_8000, '0, 32'sh0001_0000, 24'd5);               // -0.5
    read_pixel(10'd11, 9'd11);
    read_pixel(10'd10, 9'd10);
  endtask

  task automatic test_random_phase(int count, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    new_ray_pool();
    random_items(count);
  endtask

  // receiver stops for a long stretch while items keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        recv_hold = 1'b1;
        repeat (4000) @(posedge clk);
        recv_hold = 1'b0;
      end
      random_items(40);
    join
  endtask

  // --------------------------------------------------------------------------
  // stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    kshadow = '{ppdb_pkg::K00_RESET, ppdb_pkg::K01_RESET, ppdb_pkg::K02_RESET,
                ppdb_pkg::K10_RESET, ppdb_pkg::K11_RESET, ppdb_pkg::K12_RESET};
    width_shadow  = ppdb_pkg::WIDTH_RESET;
    height_shadow = ppdb_pkg::HEIGHT_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed_defaults();
    test_rounding();

    // reset camera again, sender idles often, receiver more
    load_camera(ppdb_pkg::K00_RESET, ppdb_pkg::K01_RESET, ppdb_pkg::K02_RESET,
                ppdb_pkg::K10_RESET, ppdb_pkg::K11_RESET, ppdb_pkg::K12_RESET,
                ppdb_pkg::WIDTH_RESET, ppdb_pkg::HEIGHT_RESET);
    test_random_phase(500, 38, 51);

    // full-size image, skewed camera, roles of idling swapped
    load_camera(32'd30000000, 32'd1500000, 32'd33554432, 32'hFFF0_0000,
                32'd31000000, 32'd16777216, 11'd1024, 10'd512);
    test_random_phase(450, 51, 38);
    test_backpressure();

    // oversized dimensions clip to the store size; extreme matrix entries
    load_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h0000_0000, 11'h7FF, 10'h3FF);
    test_random_phase(150, 0, 0);
    read_pixel(10'd1023, 9'd511);

    // zero width: every read and every splat with nonzero z lands outside
    load_camera($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                11'd0, 10'd1);
    test_random_phase(60, 0, 0);

    // tiny image, heavy collisions, then one more clear
    load_camera(32'd1000000, 0, 32'd524288, 0, 32'd1000000, 32'd524288,
                11'd16, 10'd16);
    test_random_phase(300, 0, 0);
    clear_image();
    test_random_phase(300, 0, 0);

    wait_idle();
    if (err_count == 0) begin
      $display("PASS point_projection_depth_buffer");
    end else begin
      $display("FAIL point_projection_depth_buffer");
    end
    $finish;
  end

  // receiver: random stalls, plus the long hold-off
  always @(posedge clk) begin
    if (rst || recv_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void check_field(string name, logic [31:0] exp_v,
      logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  // result monitor
  always @(posedge clk) begin
    pixel_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected");
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", 32'(exp_r.status), 32'(status));
        check_field("pixel_col", 32'(exp_r.col), 32'(pixel_col));
        check_field("pixel_row", 32'(exp_r.row), 32'(pixel_row));
        check_field("replaced", 32'(exp_r.replaced), 32'(replaced));
        check_field("depth_out", exp_r.depth, depth_out);
        check_field("index_out", 32'(exp_r.index), 32'(index_out));
        check_field("index_valid", 32'(exp_r.ivalid), 32'(index_valid));
      end
    end
  end

  // watchdog
  longint cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("FAIL point_projection_depth_buffer");
      $finish;
    end
  end

endmodule

>>> sim.f
hdl/ppdb_pkg.sv
hdl/ppdb_queue.sv
hdl/ppdb_front.sv
hdl/ppdb_back.sv
hdl/point_projection_depth_buffer.sv
tb/tb_point_projection_depth_buffer.sv
